FILE: rtl/core/gregorian_date_arithmetic_macros.svh
// ----------------------------------------------------------------------------
// Gregorian date arithmetic - assertion macros
// Shared concurrent check forms, clocked on the rising edge with reset held off.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_ARITHMETIC_MACROS_SVH

// Same-cycle implication
`define GDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gda: same-cycle check failed");

// Next-cycle implication
`define GDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gda: next-cycle check failed");

`endif

FILE: rtl/core/gda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_pkg
// Types, widths, calendar constants and month-length lookup for the date unit.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int MAX_YEAR = 9999;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int CNT_W  = 23;
    localparam int DN_W   = 22;   // day number of a valid date
    localparam int ACC_W  = 24;   // signed working width of the day adder
    localparam int Q100_W = 7;    // (year - 1) / 100 for a valid year

    // first day number past the last day of MAX_YEAR
    localparam int DAYS_LIMIT = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                              + MAX_YEAR / 400;

    localparam logic [ACC_W-1:0] LIMIT_DN  = ACC_W'(DAYS_LIMIT);
    localparam logic [ACC_W-1:0] DAYS_400Y = ACC_W'(146097);
    localparam logic [ACC_W-1:0] DAYS_100Y = ACC_W'(36524);
    localparam logic [ACC_W-1:0] DAYS_4Y   = ACC_W'(1461);
    localparam logic [ACC_W-1:0] DAYS_1Y   = ACC_W'(365);

    // x / 100 == (x * 5243) >> 19 for every 14-bit x
    localparam logic [12:0] RECIP100       = 13'd5243;
    localparam int          RECIP100_SH    = 19;
    localparam int          RECIP100_SH_HI = RECIP100_SH + Q100_W - 1;

    localparam logic signed [CNT_W-1:0] DB_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] DB_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_DIFF = 2'd2,
        OP_CMP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef struct packed {
        t_op                      req_type;
        logic [YEAR_W-1:0]        a_year;
        logic [MON_W-1:0]         a_month;
        logic [DAY_W-1:0]         a_day;
        logic [YEAR_W-1:0]        b_year;
        logic [MON_W-1:0]         b_month;
        logic [DAY_W-1:0]         b_day;
        logic signed [CNT_W-1:0]  day_count;
    } t_req;

    typedef struct packed {
        logic [YEAR_W-1:0]        res_year;
        logic [MON_W-1:0]         res_month;
        logic [DAY_W-1:0]         res_day;
        logic signed [CNT_W-1:0]  days_between;
        logic                     is_less;
        logic                     is_equal;
        t_status                  status;
    } t_res;

    typedef struct packed {
        logic              sub;
        logic [ACC_W-1:0]  opa;
        logic [ACC_W-1:0]  opb;
    } t_alu_req;

    typedef struct packed {
        logic [ACC_W-1:0]  sum;
        logic              neg;
        logic              zero;
    } t_alu_rsp;

    function automatic logic [DAY_W-1:0] days_in_month(input logic leap,
                                                       input logic [MON_W-1:0] month);
        logic [DAY_W-1:0] len;
        len = '0;
        if (month != '0 && month <= MON_W'(12)) begin
            if (month == MON_W'(2) && leap) begin
                len = DAY_W'(29);
            end else begin
                len = MONTH_LEN[month];
            end
        end
        return len;
    endfunction

endpackage

FILE: rtl/core/gda_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_alu
// Shared day-number adder/subtractor with sign and zero flags.
// ----------------------------------------------------------------------------
module gda_alu (
    input  gda_pkg::t_alu_req i_req,
    output gda_pkg::t_alu_rsp o_rsp
);

    logic [gda_pkg::ACC_W-1:0] w_opb;
    logic [gda_pkg::ACC_W-1:0] w_sum;

    assign w_opb = i_req.sub ? ~i_req.opb : i_req.opb;
    assign w_sum = i_req.opa + w_opb + {{(gda_pkg::ACC_W-1){1'b0}}, i_req.sub};

    assign o_rsp.sum  = w_sum;
    assign o_rsp.neg  = w_sum[gda_pkg::ACC_W-1];
    assign o_rsp.zero = (w_sum == '0);

endmodule

FILE: rtl/core/gda_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_seq
// Sequencer: converts dates to day numbers, adds or compares, and walks a day
// number back to a date, all through one shared adder.
// ----------------------------------------------------------------------------
module gda_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  gda_pkg::t_req   i_req,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output gda_pkg::t_res   o_res
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_DIV  = 13'b0000000000010,
        S_YEAR = 13'b0000000000100,
        S_MON  = 13'b0000000001000,
        S_ADD  = 13'b0000000010000,
        S_LIM  = 13'b0000000100000,
        S_Y400 = 13'b0000001000000,
        S_Y100 = 13'b0000010000000,
        S_Y4   = 13'b0000100000000,
        S_Y1   = 13'b0001000000000,
        S_RMON = 13'b0010000000000,
        S_CMP  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    t_state                      r_state, n_state;
    gda_pkg::t_req               r_req, n_req;
    gda_pkg::t_res               r_res, n_res;
    logic [gda_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [gda_pkg::DN_W-1:0]    r_na, n_na;
    logic [gda_pkg::Q100_W-1:0]  r_q100, n_q100;
    logic                        r_leap, n_leap;
    logic [gda_pkg::MON_W-1:0]   r_k, n_k;
    logic [4:0]                  r_cnt, n_cnt;
    logic [1:0]                  r_cc, n_cc;
    logic [4:0]                  r_qc, n_qc;
    logic [gda_pkg::YEAR_W-1:0]  r_yr, n_yr;
    logic                        r_pass_b, n_pass_b;

    logic [gda_pkg::YEAR_W-1:0]  w_y;
    logic [gda_pkg::MON_W-1:0]   w_m;
    logic [gda_pkg::DAY_W-1:0]   w_d;
    logic [gda_pkg::YEAR_W-1:0]  w_p;
    logic [26:0]                 w_prod;
    logic [gda_pkg::YEAR_W-1:0]  w_rem;
    logic [gda_pkg::DN_W-1:0]    w_dby;
    logic                        w_leap_in;
    logic                        w_bad_ymd;
    logic                        w_op_date;
    gda_pkg::t_alu_req           w_alu_req;
    gda_pkg::t_alu_rsp           w_alu_rsp;

    gda_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    // date under conversion
    assign w_y = r_pass_b ? r_req.b_year  : r_req.a_year;
    assign w_m = r_pass_b ? r_req.b_month : r_req.a_month;
    assign w_d = r_pass_b ? r_req.b_day   : r_req.a_day;
    assign w_p = w_y - gda_pkg::YEAR_W'(1);

    assign w_prod = {13'd0, w_p} * {14'd0, gda_pkg::RECIP100};
    assign w_rem  = w_p - ({7'd0, r_q100} * gda_pkg::YEAR_W'(100));
    // days before year y: p*365 + p/4 - p/100 + p/400
    assign w_dby  = ({8'd0, w_p} * gda_pkg::DN_W'(365)) + {10'd0, w_p[13:2]}
                  - {15'd0, r_q100} + {17'd0, r_q100[6:2]};
    // fourth year of a four-year block, unless it closes a plain century
    assign w_leap_in = (w_rem[1:0] == 2'd3) && ((w_rem[6:2] != 5'd24) || (r_q100[1:0] == 2'd3));

    assign w_bad_ymd = (w_y == '0) || (w_y > gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR))
                    || (w_m == '0) || (w_m > gda_pkg::MON_W'(12)) || (w_d == '0);
    assign w_op_date = (r_req.req_type == gda_pkg::OP_ADD) || (r_req.req_type == gda_pkg::OP_SUB);

    always_comb begin
        w_alu_req.sub = 1'b1;
        w_alu_req.opa = r_acc;
        w_alu_req.opb = '0;
        case (r_state)
            S_MON: begin
                w_alu_req.sub = 1'b0;
                if (r_k < w_m) begin
                    w_alu_req.opb = gda_pkg::ACC_W'(gda_pkg::days_in_month(r_leap, r_k));
                end else begin
                    w_alu_req.opb = gda_pkg::ACC_W'(w_d - gda_pkg::DAY_W'(1));
                end
            end
            S_ADD: begin
                w_alu_req.sub = (r_req.req_type == gda_pkg::OP_SUB);
                w_alu_req.opa = gda_pkg::ACC_W'(r_na);
                w_alu_req.opb = gda_pkg::ACC_W'(r_req.day_count);
            end
            S_LIM:  w_alu_req.opb = gda_pkg::LIMIT_DN;
            S_Y400: w_alu_req.opb = gda_pkg::DAYS_400Y;
            S_Y100: w_alu_req.opb = gda_pkg::DAYS_100Y;
            S_Y4:   w_alu_req.opb = gda_pkg::DAYS_4Y;
            S_Y1:   w_alu_req.opb = gda_pkg::DAYS_1Y;
            S_RMON: w_alu_req.opb = gda_pkg::ACC_W'(gda_pkg::days_in_month(r_leap, r_k));
            S_CMP: begin
                w_alu_req.opa = gda_pkg::ACC_W'(r_na);
                w_alu_req.opb = r_acc;
            end
            default: begin
                w_alu_req.sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_res    = r_res;
        n_acc    = r_acc;
        n_na     = r_na;
        n_q100   = r_q100;
        n_leap   = r_leap;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_cc     = r_cc;
        n_qc     = r_qc;
        n_yr     = r_yr;
        n_pass_b = r_pass_b;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req    = i_req;
                    n_res    = '0;
                    n_pass_b = 1'b0;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                n_q100 = w_prod[gda_pkg::RECIP100_SH_HI:gda_pkg::RECIP100_SH];
                if (w_bad_ymd) begin
                    n_res.status = gda_pkg::ST_BAD_DATE;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                n_acc  = gda_pkg::ACC_W'(w_dby);
                n_leap = w_leap_in;
                n_k    = gda_pkg::MON_W'(1);
                if (w_d > gda_pkg::days_in_month(w_leap_in, w_m)) begin
                    n_res.status = gda_pkg::ST_BAD_DATE;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_MON;
                end
            end
            S_MON: begin
                n_acc = w_alu_rsp.sum;
                if (r_k < w_m) begin
                    n_k = r_k + gda_pkg::MON_W'(1);
                end else if (!r_pass_b) begin
                    n_na = w_alu_rsp.sum[gda_pkg::DN_W-1:0];
                    if (w_op_date) begin
                        n_state = S_ADD;
                    end else begin
                        n_pass_b = 1'b1;
                        n_state  = S_DIV;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            S_ADD: begin
                n_acc = w_alu_rsp.sum;
                if (w_alu_rsp.neg) begin
                    n_res.status = gda_pkg::ST_RANGE;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_LIM;
                end
            end
            S_LIM: begin
                n_yr  = gda_pkg::YEAR_W'(1);
                n_cnt = '0;
                if (!w_alu_rsp.neg) begin
                    n_res.status = gda_pkg::ST_RANGE;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_Y400;
                end
            end
            S_Y400: begin
                if (!w_alu_rsp.neg) begin
                    n_acc = w_alu_rsp.sum;
                    n_yr  = r_yr + gda_pkg::YEAR_W'(400);
                end else begin
                    n_state = S_Y100;
                end
            end
            S_Y100: begin
                // the last century of a 400-year block is one day longer: cap at three
                if (!w_alu_rsp.neg && r_cnt != 5'd3) begin
                    n_acc = w_alu_rsp.sum;
                    n_yr  = r_yr + gda_pkg::YEAR_W'(100);
                    n_cnt = r_cnt + 5'd1;
                end else begin
                    n_cc    = r_cnt[1:0];
                    n_cnt   = '0;
                    n_state = S_Y4;
                end
            end
            S_Y4: begin
                if (!w_alu_rsp.neg) begin
                    n_acc = w_alu_rsp.sum;
                    n_yr  = r_yr + gda_pkg::YEAR_W'(4);
                    n_cnt = r_cnt + 5'd1;
                end else begin
                    n_qc    = r_cnt;
                    n_cnt   = '0;
                    n_state = S_Y1;
                end
            end
            S_Y1: begin
                if (!w_alu_rsp.neg && r_cnt != 5'd3) begin
                    n_acc = w_alu_rsp.sum;
                    n_yr  = r_yr + gda_pkg::YEAR_W'(1);
                    n_cnt = r_cnt + 5'd1;
                end else begin
                    n_leap  = (r_cnt == 5'd3) && ((r_qc != 5'd24) || (r_cc == 2'd3));
                    n_k     = gda_pkg::MON_W'(1);
                    n_state = S_RMON;
                end
            end
            S_RMON: begin
                if (!w_alu_rsp.neg && r_k != gda_pkg::MON_W'(12)) begin
                    n_acc = w_alu_rsp.sum;
                    n_k   = r_k + gda_pkg::MON_W'(1);
                end else begin
                    n_res.res_year  = r_yr;
                    n_res.res_month = r_k;
                    n_res.res_day   = r_acc[gda_pkg::DAY_W-1:0] + gda_pkg::DAY_W'(1);
                    n_state         = S_DONE;
                end
            end
            S_CMP: begin
                n_res.is_less  = w_alu_rsp.neg;
                n_res.is_equal = w_alu_rsp.zero;
                if (r_req.req_type == gda_pkg::OP_DIFF) begin
                    if (w_alu_rsp.sum[gda_pkg::ACC_W-1] != w_alu_rsp.sum[gda_pkg::ACC_W-2]) begin
                        n_res.days_between = w_alu_rsp.neg ? gda_pkg::DB_MIN : gda_pkg::DB_MAX;
                        n_res.status       = gda_pkg::ST_RANGE;
                    end else begin
                        n_res.days_between = w_alu_rsp.sum[gda_pkg::CNT_W-1:0];
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_res    <= n_res;
        r_acc    <= n_acc;
        r_na     <= n_na;
        r_q100   <= n_q100;
        r_leap   <= n_leap;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_cc     <= n_cc;
        r_qc     <= n_qc;
        r_yr     <= n_yr;
        r_pass_b <= n_pass_b;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

FILE: rtl/core/gregorian_date_arithmetic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// Proleptic Gregorian date add, subtract, difference and compare over streams.
// ----------------------------------------------------------------------------
// One request word is taken at a time and answered with one result word. Each
// date is turned into a day number through a divide step, a year step and a
// month step for each month up to that of the date; add and subtract then walk
// the day number back into a date by stepping 400-year, century, four-year, year
// and month chunks. The month, add, range, walk-back and compare steps all go
// through the single 24-bit add/subtract unit.
// A finished result sits in the output register, so the next request word is
// taken as soon as the sequencer is back in idle.
// ----------------------------------------------------------------------------
`include "gregorian_date_arithmetic_macros.svh"

module gregorian_date_arithmetic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // a_year, a_month, a_day, b_year, b_month, b_day, day_count, zero pad
    input  logic [71:0] s_axis_tdata,
    // req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_year, res_month, res_day, days_between, is_less, is_equal
    output logic [47:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser
);

    gda_pkg::t_req w_req;
    gda_pkg::t_res w_res;
    logic          w_res_valid;
    logic          w_res_ready;
    logic          w_in_acc;

    logic          r_m_valid, n_m_valid;
    gda_pkg::t_res r_m_res, n_m_res;

    assign w_req.req_type  = gda_pkg::t_op'(s_axis_tuser);
    assign w_req.a_year    = s_axis_tdata[13:0];
    assign w_req.a_month   = s_axis_tdata[17:14];
    assign w_req.a_day     = s_axis_tdata[22:18];
    assign w_req.b_year    = s_axis_tdata[36:23];
    assign w_req.b_month   = s_axis_tdata[40:37];
    assign w_req.b_day     = s_axis_tdata[45:41];
    assign w_req.day_count = s_axis_tdata[68:46];

    gda_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    // take a new word when the output stage is empty or draining
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_res   = r_m_res;
        if (w_res_valid && w_res_ready) begin
            n_m_valid = 1'b1;
            n_m_res   = w_res;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_res <= n_m_res;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_res.is_equal, r_m_res.is_less, r_m_res.days_between,
                            r_m_res.res_day, r_m_res.res_month, r_m_res.res_year};
    assign m_axis_tuser  = r_m_res.status;

    // one request at a time: busy straight after a word is taken
    `GDA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !s_axis_tready)
    // a bad date clears every other field
    `GDA_ASSERT_NOW(a_bad_date_zero, i_clk, i_rst_n,
        r_m_valid && (r_m_res.status == gda_pkg::ST_BAD_DATE), m_axis_tdata == '0)
    // no result date unless the request succeeded
    `GDA_ASSERT_NOW(a_fail_no_date, i_clk, i_rst_n,
        r_m_valid && (r_m_res.status != gda_pkg::ST_OK),
        (r_m_res.res_year == '0) && (r_m_res.res_month == '0) && (r_m_res.res_day == '0))
    // less-than and equal are exclusive
    `GDA_ASSERT_NOW(a_lt_eq_excl, i_clk, i_rst_n, r_m_valid,
        !(r_m_res.is_less && r_m_res.is_equal))

endmodule
